FILE: design/fts_pkg.sv
// shared types and codes for the fifo thread scheduler
`default_nettype none
package fts_pkg;

  // event codes
  localparam logic [2:0] FN_START   = 3'd0;
  localparam logic [2:0] FN_READY   = 3'd1;
  localparam logic [2:0] FN_PREEMPT = 3'd2;
  localparam logic [2:0] FN_WAIT    = 3'd3;
  localparam logic [2:0] FN_SCHED   = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  // input transaction
  typedef struct packed {
    logic [2:0] func;
    logic [7:0] thread_id;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] next_thread;
    logic       next_valid;
  } out_item_t;

  // queue control from the event decoder
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  // queue status back to the event decoder
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage
`default_nettype wire

FILE: design/fifo_thread_scheduler.sv
// top level of the fifo thread scheduler: thread table, event decoder and ready queue
`default_nettype none
// One event is taken in every clock cycle: busy is always low, and the result of
// an event accepted at one edge is shown with out_strobe high for the single
// following cycle, so there is no stall on either side. Each event needs one update
// of the per-thread used flags and one shift or fill of the ready queue cell row,
// both registered at the same edge as the result. The queue needs no clearing after
// reset; the thread table is cleared at once by reset. The receiver must take
// every result in the cycle it is shown.
module fifo_thread_scheduler #(
  parameter int THREAD_COUNT = 16,
  parameter int QUEUE_DEPTH  = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire fts_pkg::in_item_t in_item,
  output logic                   out_strobe,
  output fts_pkg::out_item_t     out_item
);
  import fts_pkg::*;

  localparam int ID_W = $clog2(THREAD_COUNT);

  // only the unused state is observable, so each thread keeps one used flag
  logic [THREAD_COUNT-1:0] thread_used_r;
  logic [THREAD_COUNT-1:0] thread_used_nxt;
  logic                    out_strobe_r;
  out_item_t               out_item_r;
  out_item_t               out_item_nxt;

  q_ctrl_t          q_ctrl;
  q_stat_t          q_stat;
  logic [ID_W-1:0]  head_id;
  logic [ID_W-1:0]  id_idx;
  logic             id_ok;
  logic             accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign id_ok  = {1'b0, in_item.thread_id} < 9'(THREAD_COUNT);
  assign id_idx = in_item.thread_id[ID_W-1:0];

  // event decode
  always_comb begin
    thread_used_nxt          = thread_used_r;
    q_ctrl                   = '0;
    out_item_nxt.status      = ST_OK;
    out_item_nxt.next_thread = '0;
    out_item_nxt.next_valid  = 1'b0;
    if (accept) begin
      case (in_item.func)
        FN_START: begin
          if (!id_ok || thread_used_r[id_idx]) begin
            out_item_nxt.status = ST_BAD;
          end else begin
            thread_used_nxt[id_idx] = 1'b1;
          end
        end
        FN_READY, FN_PREEMPT: begin
          if (!id_ok) begin
            out_item_nxt.status = ST_BAD;
          end else begin
            thread_used_nxt[id_idx] = 1'b1;
            if (q_stat.full) begin
              out_item_nxt.status = ST_FULL;
            end else begin
              q_ctrl.push = 1'b1;
            end
          end
        end
        FN_WAIT: begin
          if (!id_ok) begin
            out_item_nxt.status = ST_BAD;
          end else begin
            thread_used_nxt[id_idx] = 1'b1;
          end
        end
        FN_SCHED: begin
          if (q_stat.empty) begin
            out_item_nxt.status = ST_EMPTY;
          end else begin
            q_ctrl.pop               = 1'b1;
            out_item_nxt.next_thread = 8'(head_id);
            out_item_nxt.next_valid  = 1'b1;
          end
        end
        default: begin
          out_item_nxt.status = ST_BAD;
        end
      endcase
    end
  end

  // ready queue
  fts_ready_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ID_W       (ID_W)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (q_ctrl),
    .push_id (id_idx),
    .stat    (q_stat),
    .head_id (head_id)
  );

  // table and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thread_used_r <= '0;
      out_strobe_r  <= 1'b0;
    end else begin
      thread_used_r <= thread_used_nxt;
      out_strobe_r  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // checks
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_strobe)
    else $error("accepted transaction gave no result");
  a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.next_valid |-> out_item.status == ST_OK)
    else $error("scheduled thread with failing status");
  a_empty_sched: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_item.func == FN_SCHED && q_stat.empty
      |=> out_item.status == ST_EMPTY && !out_item.next_valid)
    else $error("schedule on empty queue not reported");

endmodule
`default_nettype wire

FILE: design/fts_queue_cell.sv
// one slot of the shifting ready queue
`default_nettype none
module fts_queue_cell #(
  parameter int ID_W = 4
) (
  input  wire logic            clk,
  input  wire logic            pop,
  input  wire logic            load,
  input  wire logic [ID_W-1:0] load_data,
  input  wire logic [ID_W-1:0] next_data,
  output logic      [ID_W-1:0] data
);

  logic [ID_W-1:0] data_r;
  logic [ID_W-1:0] data_nxt;

  // pop moves the neighbour's id one place towards the head, push fills the free slot
  always_comb begin
    data_nxt = data_r;
    if (pop) begin
      data_nxt = next_data;
    end else if (load) begin
      data_nxt = load_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule
`default_nettype wire

FILE: design/fts_ready_queue.sv
// ready queue built as a row of shifting cells with a fill count
`default_nettype none
module fts_ready_queue #(
  parameter int QUEUE_DEPTH = 32,
  parameter int ID_W        = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire fts_pkg::q_ctrl_t ctrl,
  input  wire logic [ID_W-1:0]  push_id,
  output fts_pkg::q_stat_t      stat,
  output logic      [ID_W-1:0]  head_id
);
  import fts_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [ID_W-1:0]  cell_data [QUEUE_DEPTH];

  // fill count: cell 0 is the head, cell count_r the next free slot
  always_comb begin
    count_nxt = count_r;
    if (ctrl.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // row of cells, each fed by its neighbour nearer the tail
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [ID_W-1:0] nb_data;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nb_data = '0;
    end else begin : g_mid
      assign nb_data = cell_data[i+1];
    end
    fts_queue_cell #(
      .ID_W(ID_W)
    ) u_cell (
      .clk       (clk),
      .pop       (ctrl.pop),
      .load      (ctrl.push && (count_r == CNT_W'(i))),
      .load_data (push_id),
      .next_data (nb_data),
      .data      (cell_data[i])
    );
  end

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head_id    = cell_data[0];

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("ready queue count beyond depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.push |-> !stat.full && !ctrl.pop)
    else $error("push into full queue or together with pop");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.pop |-> !stat.empty)
    else $error("pop from empty queue");

endmodule
`default_nettype wire
